// ===== rtl/pdi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdi_pkg: shared widths and types for the point distance / square root block
// Field widths, root step count and the data handed between root cells.
// ----------------------------------------------------------------------------
package pdi_pkg;

    localparam int COORD_W      = 15;   // width of each coordinate port
    localparam int COORD_BITS_D = 15;   // default coordinate bits in use
    localparam int RAD_W        = 32;
    localparam int ROOT_W       = 16;
    localparam int ROOT_STEPS   = 16;   // one result bit per cell

    localparam logic MODE_ROOT = 1'b0;
    localparam logic MODE_DIST = 1'b1;

    // partial remainder and root accumulator moving down the cell chain
    typedef struct packed {
        logic [RAD_W-1:0] rest;
        logic [RAD_W-1:0] acc;
    } cell_data_t;

endpackage

// ===== rtl/point_distance_isqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_distance_isqrt: integer square root and point distance
// Floor square root of a 32-bit radicand or of a squared point distance.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with mode, the two points and the radicand. busy is tied low,
//   so an item is taken on every cycle that start is high. Mode 0 roots the
//   radicand; mode 1 roots dx*dx + dy*dy using the low COORD_BITS bits of
//   each coordinate.
//   Each item yields one root, shown on root for a single cycle with done
//   high. The receiver cannot hold results off and none is needed: items
//   move down a fixed pipeline without stalls.
//   The result passes 3 front-end stages for difference, square and select,
//   then 16 root cells, one result bit each. Throughput: one item per cycle.
//   Reset clears all valid flags; items in flight are dropped and no done
//   pulse follows until new items arrive.
// ----------------------------------------------------------------------------
module point_distance_isqrt #(
    parameter int COORD_BITS = pdi_pkg::COORD_BITS_D
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        mode,
    input  logic [pdi_pkg::COORD_W-1:0] first_x,
    input  logic [pdi_pkg::COORD_W-1:0] first_y,
    input  logic [pdi_pkg::COORD_W-1:0] second_x,
    input  logic [pdi_pkg::COORD_W-1:0] second_y,
    input  logic [pdi_pkg::RAD_W-1:0]   radicand,
    output logic [pdi_pkg::ROOT_W-1:0]  root,
    output logic                        done
);

    localparam int N = pdi_pkg::ROOT_STEPS;

    logic                      op_valid;
    logic [pdi_pkg::RAD_W-1:0] operand;

    // taps between cells; tap 0 feeds the first cell
    logic                valid_tap [N+1];
    pdi_pkg::cell_data_t data_tap  [N+1];

    assign busy = 1'b0;

    pdi_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start & ~busy),
        .mode     (mode),
        .first_x  (first_x),
        .first_y  (first_y),
        .second_x (second_x),
        .second_y (second_y),
        .radicand (radicand),
        .op_valid (op_valid),
        .operand  (operand)
    );

    assign valid_tap[0]     = op_valid;
    assign data_tap[0].rest = operand;
    assign data_tap[0].acc  = '0;

    for (genvar k = 0; k < N; k++)
    begin : g_cell
        pdi_root_cell #(
            .STEP (k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (valid_tap[k]),
            .in_data   (data_tap[k]),
            .out_valid (valid_tap[k+1]),
            .out_data  (data_tap[k+1])
        );
    end

    assign done = valid_tap[N];
    assign root = data_tap[N].acc[pdi_pkg::ROOT_W-1:0];

endmodule

// ===== rtl/pdi_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdi_front: operand front end
// Three stages: absolute differences, squares, then sum and mode select.
// ----------------------------------------------------------------------------
module pdi_front #(
    parameter int COORD_BITS = pdi_pkg::COORD_BITS_D
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        mode,
    input  logic [pdi_pkg::COORD_W-1:0] first_x,
    input  logic [pdi_pkg::COORD_W-1:0] first_y,
    input  logic [pdi_pkg::COORD_W-1:0] second_x,
    input  logic [pdi_pkg::COORD_W-1:0] second_y,
    input  logic [pdi_pkg::RAD_W-1:0]   radicand,
    output logic                        op_valid,
    output logic [pdi_pkg::RAD_W-1:0]   operand
);

    localparam int SQ_W  = 2 * COORD_BITS;
    localparam int SUM_W = SQ_W + 1;

    logic [COORD_BITS-1:0] ax, ay, bx, by;
    logic [COORD_BITS-1:0] dx_next, dy_next;
    logic [SUM_W-1:0]      sum;

    // stage 1
    logic                      v1_reg;
    logic                      mode1_reg;
    logic [COORD_BITS-1:0]     dx_reg, dy_reg;
    logic [pdi_pkg::RAD_W-1:0] rad1_reg;
    // stage 2
    logic                      v2_reg;
    logic                      mode2_reg;
    logic [SQ_W-1:0]           sqx_reg, sqy_reg;
    logic [pdi_pkg::RAD_W-1:0] rad2_reg;
    // stage 3
    logic                      v3_reg;
    logic [pdi_pkg::RAD_W-1:0] op_reg;
    logic [pdi_pkg::RAD_W-1:0] op_next;

    assign ax = first_x[COORD_BITS-1:0];
    assign ay = first_y[COORD_BITS-1:0];
    assign bx = second_x[COORD_BITS-1:0];
    assign by = second_y[COORD_BITS-1:0];

    assign dx_next = (ax >= bx) ? ax - bx : bx - ax;
    assign dy_next = (ay >= by) ? ay - by : by - ay;

    assign sum     = SUM_W'(sqx_reg) + SUM_W'(sqy_reg);
    assign op_next = (mode2_reg == pdi_pkg::MODE_DIST) ? pdi_pkg::RAD_W'(sum) : rad2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mode1_reg <= mode;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        rad1_reg  <= radicand;

        mode2_reg <= mode1_reg;
        sqx_reg   <= SQ_W'(dx_reg) * SQ_W'(dx_reg);
        sqy_reg   <= SQ_W'(dy_reg) * SQ_W'(dy_reg);
        rad2_reg  <= rad1_reg;

        op_reg    <= op_next;
    end

    assign op_valid = v3_reg;
    assign operand  = op_reg;

endmodule

// ===== rtl/pdi_root_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdi_root_cell: one digit step of the bit-by-bit square root
// Trial subtract of acc + place, then registers the new remainder and acc.
// ----------------------------------------------------------------------------
module pdi_root_cell #(
    parameter int STEP = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  pdi_pkg::cell_data_t in_data,
    output logic                out_valid,
    output pdi_pkg::cell_data_t out_data
);

    localparam int            TW    = pdi_pkg::RAD_W + 1;
    localparam int            SHIFT = pdi_pkg::RAD_W - 2 - 2 * STEP;
    localparam logic [TW-1:0] PLACE = TW'(1) << SHIFT;

    logic [TW-1:0]       trial;
    logic                take;
    pdi_pkg::cell_data_t data_next;
    pdi_pkg::cell_data_t data_reg;
    logic                valid_reg;

    always_comb
    begin
        trial = TW'(in_data.acc) + PLACE;
        take  = TW'(in_data.rest) >= trial;
        if (take)
        begin
            data_next.rest = in_data.rest - trial[pdi_pkg::RAD_W-1:0];
            data_next.acc  = (in_data.acc >> 1) + PLACE[pdi_pkg::RAD_W-1:0];
        end
        else
        begin
            data_next.rest = in_data.rest;
            data_next.acc  = in_data.acc >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== bench/tb_point_distance_isqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_point_distance_isqrt: self-checking bench for point_distance_isqrt
// Drives a directed table, then 1600 random items in both modes, with
// random gaps on start. Each root is checked against a bit-serial floor-sqrt
// predictor, or against a value typed into the table for the plain cases.
// ----------------------------------------------------------------------------
module tb_point_distance_isqrt;

    localparam int LATENCY      = 19;
    localparam int DRAIN_CYCLES = LATENCY + 8;
    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 1600;
    localparam int QUIET_FIRST  = 600;   // no gaps on start for this stretch
    localparam int QUIET_LAST   = 999;
    localparam int IDLE_PCT     = 7;

    localparam logic GIVEN   = 1'b1;     // root typed into the table
    localparam logic PREDICT = 1'b0;     // root from the predictor

    localparam logic [pdi_pkg::COORD_W-1:0] CMAX = {pdi_pkg::COORD_W{1'b1}};

    typedef struct packed {
        logic                        mode;
        logic [pdi_pkg::COORD_W-1:0] ax;
        logic [pdi_pkg::COORD_W-1:0] ay;
        logic [pdi_pkg::COORD_W-1:0] bx;
        logic [pdi_pkg::COORD_W-1:0] by;
        logic [pdi_pkg::RAD_W-1:0]   rad;
        logic                        typed;
        logic [pdi_pkg::ROOT_W-1:0]  root;
    } query_t;

    logic                        clk;
    logic                        rst_n;
    logic                        start;
    logic                        busy;
    logic                        mode;
    logic [pdi_pkg::COORD_W-1:0] first_x;
    logic [pdi_pkg::COORD_W-1:0] first_y;
    logic [pdi_pkg::COORD_W-1:0] second_x;
    logic [pdi_pkg::COORD_W-1:0] second_y;
    logic [pdi_pkg::RAD_W-1:0]   radicand;
    logic [pdi_pkg::ROOT_W-1:0]  root;
    logic                        done;

    // typed expectation riding along with the item on the ports
    logic                        hint_valid;
    logic [pdi_pkg::ROOT_W-1:0]  hint_root;

    logic [pdi_pkg::ROOT_W-1:0]  pending_roots[$];
    logic [pdi_pkg::ROOT_W-1:0]  want_root;
    query_t                      directed_rows[$];

    int unsigned        sent_count;
    int unsigned        dist_count;
    int unsigned        sqrt_count;
    int unsigned        checked_count;
    int unsigned        mismatch_count;
    int unsigned        stall_count;

    point_distance_isqrt i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .mode     (mode),
        .first_x  (first_x),
        .first_y  (first_y),
        .second_x (second_x),
        .second_y (second_y),
        .radicand (radicand),
        .root     (root),
        .done     (done)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // floor sqrt, deciding one root bit per pass from the top down
    function automatic logic [pdi_pkg::ROOT_W-1:0] floor_sqrt(
        input logic [pdi_pkg::RAD_W-1:0] v);
        logic [pdi_pkg::ROOT_W-1:0] r;
        logic [pdi_pkg::ROOT_W-1:0] trial;
        int                         b;
        r = '0;
        for (b = pdi_pkg::ROOT_W - 1; b >= 0; b--)
        begin
            trial = r | (pdi_pkg::ROOT_W'(1) << b);
            if (64'(trial) * 64'(trial) <= 64'(v))
                r = trial;
        end
        return r;
    endfunction

    function automatic logic [pdi_pkg::ROOT_W-1:0] expected_root(
        input logic m,
        input logic [pdi_pkg::COORD_W-1:0] ax,
        input logic [pdi_pkg::COORD_W-1:0] ay,
        input logic [pdi_pkg::COORD_W-1:0] bx,
        input logic [pdi_pkg::COORD_W-1:0] by,
        input logic [pdi_pkg::RAD_W-1:0] rad);
        logic [pdi_pkg::RAD_W-1:0] dx;
        logic [pdi_pkg::RAD_W-1:0] dy;
        logic [pdi_pkg::RAD_W-1:0] sum;
        if (m == pdi_pkg::MODE_DIST)
        begin
            dx  = (ax >= bx) ? pdi_pkg::RAD_W'(ax - bx) : pdi_pkg::RAD_W'(bx - ax);
            dy  = (ay >= by) ? pdi_pkg::RAD_W'(ay - by) : pdi_pkg::RAD_W'(by - ay);
            sum = dx * dx + dy * dy;   // 15-bit coordinates keep this below 2^32
        end
        else
            sum = rad;
        return floor_sqrt(sum);
    endfunction

    task automatic add_row(input logic m,
                           input logic [pdi_pkg::COORD_W-1:0] ax,
                           input logic [pdi_pkg::COORD_W-1:0] ay,
                           input logic [pdi_pkg::COORD_W-1:0] bx,
                           input logic [pdi_pkg::COORD_W-1:0] by,
                           input logic [pdi_pkg::RAD_W-1:0] rad,
                           input logic typed, input logic [pdi_pkg::ROOT_W-1:0] r);
        query_t q;
        q = '{mode: m, ax: ax, ay: ay, bx: bx, by: by, rad: rad, typed: typed, root: r};
        directed_rows.push_back(q);
    endtask

    function automatic query_t random_query();
        query_t      q;
        int unsigned k;
        q.typed = 1'b0;
        q.root  = '0;
        q.mode  = 1'($urandom_range(0, 1));

        case ($urandom_range(0, 9))
            0, 1, 2: q.rad = $urandom;
            3, 4:    q.rad = $urandom_range(0, 300);
            5, 6, 7:
            begin
                // around a perfect square, where the last root bit flips
                k     = $urandom_range(0, 65535);
                q.rad = k * k;
                case ($urandom_range(0, 2))
                    0:       q.rad = q.rad - 1;
                    1:       q.rad = q.rad + 1;
                    default: ;
                endcase
            end
            8:       q.rad = 32'hFFFF_0000 | $urandom_range(0, 65535);
            default: q.rad = pdi_pkg::RAD_W'(1) << $urandom_range(0, pdi_pkg::RAD_W - 1);
        endcase

        q.ax = pdi_pkg::COORD_W'($urandom_range(0, CMAX));
        q.ay = pdi_pkg::COORD_W'($urandom_range(0, CMAX));
        case ($urandom_range(0, 3))
            0:
            begin
                q.bx = pdi_pkg::COORD_W'($urandom_range(0, CMAX));
                q.by = pdi_pkg::COORD_W'($urandom_range(0, CMAX));
            end
            1:
            begin
                // near neighbor; the wrap at the edges gives a far one now and then
                q.bx = q.ax + pdi_pkg::COORD_W'($urandom_range(0, 16))
                       - pdi_pkg::COORD_W'(8);
                q.by = q.ay + pdi_pkg::COORD_W'($urandom_range(0, 16))
                       - pdi_pkg::COORD_W'(8);
            end
            2:
            begin
                q.bx = q.ax;
                q.by = q.ay;
            end
            default:
            begin
                q.ax = $urandom_range(0, 1) ? CMAX : '0;
                q.ay = $urandom_range(0, 1) ? CMAX : '0;
                q.bx = $urandom_range(0, 1) ? CMAX : '0;
                q.by = $urandom_range(0, 1) ? CMAX : '0;
            end
        endcase
        return q;
    endfunction

    // put one item on the ports at the falling edge, hold it until taken
    task automatic send_query(input query_t q, input bit may_idle);
        while (may_idle && $urandom_range(0, 99) < IDLE_PCT)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start      <= 1'b1;
        mode       <= q.mode;
        first_x    <= q.ax;
        first_y    <= q.ay;
        second_x   <= q.bx;
        second_y   <= q.by;
        radicand   <= q.rad;
        hint_valid <= q.typed;
        hint_root  <= q.root;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        sent_count++;
        @(negedge clk);
    endtask

    // result check, expectation capture and stall watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_roots.size() == 0)
                begin
                    $display("%0t: root %0d with no item outstanding", $time, root);
                    mismatch_count++;
                end
                else
                begin
                    want_root = pending_roots.pop_front();
                    checked_count++;
                    if (root !== want_root)
                    begin
                        $display("%0t: root mismatch: expected %0d, actual %0d",
                                 $time, want_root, root);
                        mismatch_count++;
                    end
                end
            end

            if (start && !busy)
            begin
                if (hint_valid)
                    pending_roots.push_back(hint_root);
                else
                    pending_roots.push_back(expected_root(mode, first_x, first_y,
                                                          second_x, second_y, radicand));
                if (mode == pdi_pkg::MODE_DIST)
                    dist_count++;
                else
                    sqrt_count++;
            end

            if (done || (start && !busy))
                stall_count = 0;
            else
                stall_count++;
            if (stall_count >= STALL_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles, %0d roots outstanding",
                         $time, STALL_LIMIT, pending_roots.size());
                $display("tb_point_distance_isqrt: errors");
                $finish;
            end
        end
    end

    initial
    begin
        int     n;
        query_t q;

        clk            = 1'b0;
        rst_n          = 1'b0;
        start          = 1'b0;
        mode           = pdi_pkg::MODE_ROOT;
        first_x        = '0;
        first_y        = '0;
        second_x       = '0;
        second_y       = '0;
        radicand       = '0;
        hint_valid     = 1'b0;
        hint_root      = '0;
        sent_count     = 0;
        dist_count     = 0;
        sqrt_count     = 0;
        checked_count  = 0;
        mismatch_count = 0;
        stall_count    = 0;

        //      mode               ax     ay     bx     by    radicand       typed  root
        add_row(pdi_pkg::MODE_ROOT, 0,    0,     0,     0,    32'd0,         GIVEN, 16'd0);
        add_row(pdi_pkg::MODE_ROOT, 0,    0,     0,     0,    32'd1,         GIVEN, 16'd1);
        add_row(pdi_pkg::MODE_ROOT, 0,    0,     0,     0,    32'd2,         GIVEN, 16'd1);
        add_row(pdi_pkg::MODE_ROOT, 0,    0,     0,     0,    32'd3,         GIVEN, 16'd1);
        add_row(pdi_pkg::MODE_ROOT, 0,    0,     0,     0,    32'd4,         GIVEN, 16'd2);
        add_row(pdi_pkg::MODE_ROOT, 0,    0,     0,     0,    32'd15,        GIVEN, 16'd3);
        add_row(pdi_pkg::MODE_ROOT, 0,    0,     0,     0,    32'd16,        GIVEN, 16'd4);
        add_row(pdi_pkg::MODE_ROOT, 0,    0,     0,     0,    32'hFFFF_FFFF, GIVEN,
                16'd65535);
        add_row(pdi_pkg::MODE_ROOT, 0,    0,     0,     0,    32'd4294836225, GIVEN,
                16'd65535);
        add_row(pdi_pkg::MODE_ROOT, 0,    0,     0,     0,    32'd4294836224, GIVEN,
                16'd65534);
        add_row(pdi_pkg::MODE_ROOT, 0,    0,     0,     0,    32'h4000_0000, GIVEN,
                16'd32768);
        add_row(pdi_pkg::MODE_ROOT, 0,    0,     0,     0,    32'h8000_0000, PREDICT,
                16'd0);
        add_row(pdi_pkg::MODE_ROOT, 0,    0,     0,     0,    32'd12345678,  PREDICT,
                16'd0);
        // coordinates have no say in root mode
        add_row(pdi_pkg::MODE_ROOT, CMAX, CMAX,  0,     CMAX, 32'd99,        GIVEN, 16'd9);
        // radicand has no say in distance mode
        add_row(pdi_pkg::MODE_DIST, 12345, 6789, 12345, 6789, 32'hFFFF_FFFF, GIVEN, 16'd0);
        add_row(pdi_pkg::MODE_DIST, 0,    0,     0,     0,    32'd0,         GIVEN, 16'd0);
        add_row(pdi_pkg::MODE_DIST, 0,    0,     CMAX,  CMAX, 32'd0,         GIVEN,
                16'd46339);
        add_row(pdi_pkg::MODE_DIST, CMAX, CMAX,  0,     0,    32'd7,         GIVEN,
                16'd46339);
        add_row(pdi_pkg::MODE_DIST, CMAX, 0,     0,     CMAX, 32'd0,         GIVEN,
                16'd46339);
        add_row(pdi_pkg::MODE_DIST, 0,    0,     CMAX,  0,    32'd0,         GIVEN,
                16'd32767);
        add_row(pdi_pkg::MODE_DIST, 0,    CMAX,  0,     0,    32'd0,         GIVEN,
                16'd32767);
        add_row(pdi_pkg::MODE_DIST, 3,    0,     0,     4,    32'd0,         GIVEN, 16'd5);
        add_row(pdi_pkg::MODE_DIST, 100,  200,   7,     9,    32'd12345,     PREDICT,
                16'd0);
        add_row(pdi_pkg::MODE_DIST, 21845, 10922, 10922, 21845, 32'hAAAA_5555, PREDICT,
                16'd0);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        n = 0;
        foreach (directed_rows[i])
        begin
            send_query(directed_rows[i], 1'b1);
            n++;
        end
        repeat (RANDOM_ITEMS)
        begin
            q = random_query();
            send_query(q, !(n >= QUIET_FIRST && n <= QUIET_LAST));
            n++;
        end
        start <= 1'b0;

        while (pending_roots.size() != 0)
            @(posedge clk);
        // a late or extra strobe still shows up as an unexpected root
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d items sent: %0d square roots, %0d distances; %0d roots checked",
                 sent_count, sqrt_count, dist_count, checked_count);
        $display("%0d mismatches", mismatch_count);
        if (mismatch_count == 0)
            $display("tb_point_distance_isqrt: clean");
        else
            $display("tb_point_distance_isqrt: errors");
        $finish;
    end

endmodule
